[rtl/core/lzf_pkg.sv]
package lzf_pkg;

	// Parse modes of the token decoder.
	localparam logic [1:0] MODE_CTRL = 2'd0;
	localparam logic [1:0] MODE_LIT  = 2'd1;
	localparam logic [1:0] MODE_EXT  = 2'd2;
	localparam logic [1:0] MODE_DIST = 2'd3;

	localparam int LIT_LIMIT = 1 << 5;
	localparam logic [7:0] DIST_HIGH_MASK = 8'h1f;
	localparam logic [2:0] LEN_EXTENDED = 3'd7;
	localparam int LEN_BIAS = 2;

	typedef struct packed {
		logic latch_in;
		logic lit_open;
		logic ref_open;
		logic ext_add;
		logic copy_start;
		logic lit_emit;
		logic mem_rd;
		logic mem_wr;
		logic chunk_emit;
		logic final_emit;
		logic err_set;
	} lzf_cmd_t;

	typedef struct packed {
		logic byte_lt32;
		logic lit_over;
		logic ref_is_ext;
		logic copy_bad;
		logic last;
		logic lit_done;
		logic err;
		logic chunk_end;
		logic rem_zero;
		logic out_free;
	} lzf_sts_t;

endpackage

[rtl/core/lzf_ifs.sv]
interface lzf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;
	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface lzf_out_if #(parameter int BYTES_PER_RESULT = 8);
	localparam int CW = $clog2(BYTES_PER_RESULT + 1);
	logic                          valid;
	logic                          ready;
	logic [8*BYTES_PER_RESULT-1:0] data_bytes;
	logic [CW-1:0]                 byte_count;
	logic                          run_last;
	logic                          stream_end;
	logic                          decode_error;
	logic [31:0]                   total_length;
	modport source (output valid, output data_bytes, output byte_count, output run_last,
		output stream_end, output decode_error, output total_length, input ready);
	modport sink (input valid, input data_bytes, input byte_count, input run_last,
		input stream_end, input decode_error, input total_length, output ready);
endinterface

interface lzf_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/core/lzf_ctrl.sv]
module lzf_ctrl import lzf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  lzf_sts_t sts,
	output lzf_cmd_t cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DEC    = 3'd1;
	localparam logic [2:0] S_LITOUT = 3'd2;
	localparam logic [2:0] S_RD     = 3'd3;
	localparam logic [2:0] S_WR     = 3'd4;
	localparam logic [2:0] S_EMIT   = 3'd5;
	localparam logic [2:0] S_TAIL   = 3'd6;
	localparam logic [2:0] S_FINAL  = 3'd7;

	logic [2:0] state_q, state_d;
	logic [1:0] mode_q, mode_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		mode_d  = mode_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				state_d = S_TAIL;
				if (!sts.err) begin
					unique case (mode_q)
						MODE_CTRL: begin
							if (sts.byte_lt32) begin
								if (sts.lit_over) begin
									cmd.err_set = 1'b1;
								end else begin
									cmd.lit_open = 1'b1;
									mode_d = MODE_LIT;
								end
							end else begin
								cmd.ref_open = 1'b1;
								mode_d = sts.ref_is_ext ? MODE_EXT : MODE_DIST;
							end
						end
						MODE_LIT: begin
							state_d = S_LITOUT;
						end
						MODE_EXT: begin
							cmd.ext_add = 1'b1;
							mode_d = MODE_DIST;
						end
						default: begin
							mode_d = MODE_CTRL;
							if (sts.copy_bad) begin
								cmd.err_set = 1'b1;
							end else begin
								cmd.copy_start = 1'b1;
								state_d = S_RD;
							end
						end
					endcase
				end
			end
			S_LITOUT: begin
				if (sts.out_free) begin
					cmd.lit_emit = 1'b1;
					if (sts.lit_done) begin
						mode_d = MODE_CTRL;
					end
					state_d = S_TAIL;
				end
			end
			S_RD: begin
				cmd.mem_rd = 1'b1;
				state_d = S_WR;
			end
			S_WR: begin
				cmd.mem_wr = 1'b1;
				state_d = sts.chunk_end ? S_EMIT : S_RD;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.chunk_emit = 1'b1;
					state_d = sts.rem_zero ? S_TAIL : S_RD;
				end
			end
			S_TAIL: begin
				if (sts.last) begin
					if (mode_q != MODE_CTRL) begin
						cmd.err_set = 1'b1;
					end
					state_d = S_FINAL;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_FINAL: begin
				if (sts.out_free) begin
					cmd.final_emit = 1'b1;
					mode_d = MODE_CTRL;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q  <= MODE_CTRL;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
		end
	end

endmodule

[rtl/core/lzf_datapath.sv]
module lzf_datapath import lzf_pkg::*; #(
	parameter int WINDOW_BYTES     = 8192,
	parameter int BYTES_PER_RESULT = 8,
	localparam int AW = $clog2(WINDOW_BYTES),
	localparam int CW = $clog2(BYTES_PER_RESULT + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lzf_cmd_t                      cmd,
	output lzf_sts_t                      sts,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [31:0]                   cfg_data,
	input  logic [7:0]                    in_byte,
	input  logic                          in_last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [8*BYTES_PER_RESULT-1:0] out_bytes,
	output logic [CW-1:0]                 out_count,
	output logic                          out_run_last,
	output logic                          out_end,
	output logic                          out_err,
	output logic [31:0]                   out_total
);

	logic [31:0] cap_q, oc_q;
	logic        err_q, ovalid_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic [5:0]  litrem_q;
	logic [8:0]  reflen_q;
	logic [4:0]  dhigh_q;
	logic [9:0]  rem_q;
	logic [AW-1:0] src_q;
	logic [7:0]  rdata_q;
	logic [8*BYTES_PER_RESULT-1:0] acc_q;
	logic [CW-1:0] cnt_q;
	logic [7:0]  hist_mem [WINDOW_BYTES];

	logic [32:0] lit_need, copy_need;
	logic [13:0] ref_dist;
	logic [9:0]  total;
	logic        wr_en;
	logic [7:0]  wr_data;

	assign cfg_ready = 1'b1;
	assign ref_dist  = {dhigh_q, byte_q} + 14'd1;
	assign total     = {1'b0, reflen_q} + 10'(LEN_BIAS);
	assign lit_need  = {1'b0, oc_q} + 33'(byte_q) + 33'd1;
	assign copy_need = {1'b0, oc_q} + 33'(total);

	assign sts.byte_lt32  = (32'(byte_q) < 32'(LIT_LIMIT));
	assign sts.lit_over   = (lit_need > {1'b0, cap_q});
	assign sts.ref_is_ext = (byte_q[7:5] == LEN_EXTENDED);
	assign sts.copy_bad   = (copy_need > {1'b0, cap_q}) || (32'(ref_dist) > oc_q);
	assign sts.last       = last_q;
	assign sts.lit_done   = (litrem_q == 6'd1);
	assign sts.err        = err_q;
	assign sts.chunk_end  = (cnt_q == CW'(BYTES_PER_RESULT - 1)) || (rem_q == 10'd1);
	assign sts.rem_zero   = (rem_q == 10'd0);
	assign sts.out_free   = !ovalid_q || out_ready;

	assign out_valid = ovalid_q;
	assign wr_en     = cmd.mem_wr || cmd.lit_emit;
	assign wr_data   = cmd.mem_wr ? rdata_q : byte_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			hist_mem[oc_q[AW-1:0]] <= wr_data;
		end
		if (cmd.mem_rd) begin
			rdata_q <= hist_mem[src_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= '0;
			oc_q     <= '0;
			err_q    <= 1'b0;
			ovalid_q <= 1'b0;
			litrem_q <= '0;
			reflen_q <= '0;
			dhigh_q  <= '0;
			rem_q    <= '0;
			cnt_q    <= '0;
		end else begin
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
			if (cmd.lit_emit || cmd.chunk_emit || cmd.final_emit) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
			if (cmd.err_set) begin
				err_q <= 1'b1;
			end
			if (cmd.lit_open) begin
				litrem_q <= 6'(byte_q) + 6'd1;
			end
			if (cmd.ref_open) begin
				reflen_q <= 9'(byte_q[7:5]);
				dhigh_q  <= 5'(byte_q & DIST_HIGH_MASK);
			end
			if (cmd.ext_add) begin
				reflen_q <= reflen_q + 9'(byte_q);
			end
			if (cmd.copy_start) begin
				rem_q <= total;
			end
			if (cmd.lit_emit) begin
				oc_q     <= oc_q + 32'd1;
				litrem_q <= litrem_q - 6'd1;
			end
			if (cmd.mem_wr) begin
				oc_q  <= oc_q + 32'd1;
				rem_q <= rem_q - 10'd1;
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.chunk_emit) begin
				cnt_q <= '0;
			end
			if (cmd.final_emit) begin
				oc_q     <= '0;
				err_q    <= 1'b0;
				litrem_q <= '0;
				reflen_q <= '0;
				dhigh_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			byte_q <= in_byte;
			last_q <= in_last;
		end
		if (cmd.copy_start) begin
			src_q <= AW'(oc_q - 32'(ref_dist));
			acc_q <= '0;
		end
		if (cmd.mem_rd) begin
			src_q <= src_q + AW'(1);
		end
		if (cmd.mem_wr) begin
			acc_q[8*cnt_q +: 8] <= rdata_q;
		end
		if (cmd.chunk_emit) begin
			acc_q <= '0;
		end
		if (cmd.lit_emit) begin
			out_bytes    <= (8*BYTES_PER_RESULT)'(byte_q);
			out_count    <= CW'(1);
			out_run_last <= !last_q;
			out_end      <= 1'b0;
			out_err      <= err_q;
			out_total    <= oc_q + 32'd1;
		end else if (cmd.chunk_emit) begin
			out_bytes    <= acc_q;
			out_count    <= cnt_q;
			out_run_last <= (rem_q == 10'd0) && !last_q;
			out_end      <= 1'b0;
			out_err      <= err_q;
			out_total    <= oc_q;
		end else if (cmd.final_emit) begin
			out_bytes    <= '0;
			out_count    <= '0;
			out_run_last <= 1'b1;
			out_end      <= 1'b1;
			out_err      <= err_q;
			out_total    <= oc_q;
		end
	end

endmodule

[rtl/core/lzf_stream_decompressor.sv]
// LZF stream decompressor: one compressed byte per input transaction, one at a time.
// Sequence: a literal byte passes IDLE, DEC, LITOUT (which registers its result) and TAIL;
// a control, extension or distance byte passes IDLE, DEC and TAIL.
// A copy alternates RD and WR for each byte, the read data being registered in between,
// plus an EMIT state per output transaction; the final result is sent from the FINAL state.
// Reset clears the parse state, count and error flag; the history memory is not cleared.
module lzf_stream_decompressor import lzf_pkg::*; #(
	parameter int WINDOW_BYTES     = 8192,
	parameter int BYTES_PER_RESULT = 8
) (
	input logic              clk,
	input logic              arst_n,
	lzf_cfg_if.sink          cfg,
	lzf_in_if.sink           compressed,
	lzf_out_if.source        decompressed
);

	// The controller sequences token parsing and the byte-wise copy loop; the
	// datapath holds the history memory, counters and the output register.
	// WINDOW_BYTES must be a power of two so the history index wraps naturally.
	lzf_cmd_t cmd;
	lzf_sts_t sts;

	lzf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (compressed.valid),
		.in_ready (compressed.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lzf_datapath #(
		.WINDOW_BYTES     (WINDOW_BYTES),
		.BYTES_PER_RESULT (BYTES_PER_RESULT)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_valid    (cfg.valid),
		.cfg_ready    (cfg.ready),
		.cfg_data     (cfg.data),
		.in_byte      (compressed.in_byte),
		.in_last      (compressed.in_last),
		.out_valid    (decompressed.valid),
		.out_ready    (decompressed.ready),
		.out_bytes    (decompressed.data_bytes),
		.out_count    (decompressed.byte_count),
		.out_run_last (decompressed.run_last),
		.out_end      (decompressed.stream_end),
		.out_err      (decompressed.decode_error),
		.out_total    (decompressed.total_length)
	);

endmodule

[test/lzf_stream_decompressor_tb.sv]
`timescale 1ns / 100ps

module lzf_stream_decompressor_tb import lzf_pkg::*; ();

	localparam int WINDOW = 8192;
	localparam int WAW = $clog2(WINDOW);
	localparam int CHUNK = 8;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_ITEMS = 150;
	localparam logic [31:0] CAP_MAX = 32'hffff_ffff;

	// One decompressed output transaction as the block should present it.
	typedef struct {
		logic [63:0] data_bytes;
		logic [3:0]  byte_count;
		logic        run_last;
		logic        stream_end;
		logic        decode_error;
		logic [31:0] total_length;
	} out_beat_t;

	logic clk;
	logic arst_n;
	int   cycles;
	bit   failed;
	bit   no_idle;

	lzf_cfg_if cfg_if ();
	lzf_in_if in_if ();
	lzf_out_if #(.BYTES_PER_RESULT(CHUNK)) out_if ();

	lzf_stream_decompressor #(.WINDOW_BYTES(WINDOW), .BYTES_PER_RESULT(CHUNK)) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_if),
		.compressed  (in_if),
		.decompressed(out_if)
	);

	// The testbench's own image of the decoder: history, parse state and config.
	logic [7:0]  hist_mem [WINDOW];
	logic [1:0]  pmode;
	logic [5:0]  lit_left;
	logic [8:0]  copy_len;
	logic [4:0]  dist_hi;
	logic [31:0] out_cnt;
	logic        err_sticky;
	logic [31:0] capacity;

	out_beat_t pending_beats [$];

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic void queue_beat(logic [63:0] d, logic [3:0] n, logic fin);
		out_beat_t b;
		b.data_bytes = d;
		b.byte_count = n;
		b.run_last = 1'b0;
		b.stream_end = fin;
		b.decode_error = err_sticky;
		b.total_length = out_cnt;
		pending_beats.push_back(b);
	endfunction

	// Advance the decoder image by one accepted compressed byte and queue the
	// output transactions it causes. The last one of them carries run_last.
	function automatic void decode_byte(logic [7:0] b, logic last);
		int          base_size;
		logic [31:0] ref_dist;
		logic [31:0] src_pos;
		int          remain;
		logic [63:0] d;
		int          n;
		logic [7:0]  c;
		base_size = pending_beats.size();
		if (!err_sticky) begin
			case (pmode)
				MODE_CTRL: begin
					if (b < LIT_LIMIT) begin
						if ({32'd0, out_cnt} + b + 1 > {32'd0, capacity}) begin
							err_sticky = 1'b1;
						end else begin
							lit_left = 6'(b) + 6'd1;
							pmode = MODE_LIT;
						end
					end else begin
						copy_len = 9'(b >> 5);
						dist_hi = 5'(b & DIST_HIGH_MASK);
						pmode = (copy_len == LEN_EXTENDED) ? MODE_EXT : MODE_DIST;
					end
				end
				MODE_LIT: begin
					hist_mem[out_cnt[WAW-1:0]] = b;
					out_cnt++;
					queue_beat({56'd0, b}, 4'd1, 1'b0);
					lit_left--;
					if (lit_left == 0) pmode = MODE_CTRL;
				end
				MODE_EXT: begin
					copy_len = copy_len + 9'(b);
					pmode = MODE_DIST;
				end
				default: begin
					ref_dist = {19'd0, dist_hi, b} + 32'd1;
					remain = copy_len + LEN_BIAS;
					pmode = MODE_CTRL;
					if ({32'd0, out_cnt} + remain > {32'd0, capacity} || ref_dist > out_cnt) begin
						err_sticky = 1'b1;
					end else begin
						while (remain > 0) begin
							d = '0;
							n = 0;
							while (n < CHUNK && remain > 0) begin
								src_pos = out_cnt - ref_dist;
								c = hist_mem[src_pos[WAW-1:0]];
								hist_mem[out_cnt[WAW-1:0]] = c;
								out_cnt++;
								d[8*n +: 8] = c;
								n++;
								remain--;
							end
							queue_beat(d, n[3:0], 1'b0);
						end
					end
				end
			endcase
		end
		if (last) begin
			if (pmode != MODE_CTRL) err_sticky = 1'b1;
			queue_beat('0, 4'd0, 1'b1);
			pmode = MODE_CTRL;
			lit_left = '0;
			copy_len = '0;
			dist_hi = '0;
			out_cnt = '0;
			err_sticky = 1'b0;
		end
		if (pending_beats.size() > base_size)
			pending_beats[pending_beats.size() - 1].run_last = 1'b1;
	endfunction

	// Output side: each transaction is checked against the oldest expectation,
	// then the sink draws a random stall for the next one, or none under no_idle.
	int sink_wait;
	always @(posedge clk) begin
		out_beat_t e;
		if (arst_n && out_if.valid && out_if.ready) begin
			if (pending_beats.size() == 0) begin
				$error("unexpected output transaction, data_bytes %h", out_if.data_bytes);
				failed = 1'b1;
			end else begin
				e = pending_beats.pop_front();
				if (out_if.data_bytes !== e.data_bytes) begin
					$error("data_bytes expected %h actual %h", e.data_bytes, out_if.data_bytes);
					failed = 1'b1;
				end
				if (out_if.byte_count !== e.byte_count) begin
					$error("byte_count expected %0d actual %0d", e.byte_count,
						out_if.byte_count);
					failed = 1'b1;
				end
				if (out_if.run_last !== e.run_last) begin
					$error("run_last expected %0d actual %0d", e.run_last, out_if.run_last);
					failed = 1'b1;
				end
				if (out_if.stream_end !== e.stream_end) begin
					$error("stream_end expected %0d actual %0d", e.stream_end,
						out_if.stream_end);
					failed = 1'b1;
				end
				if (out_if.decode_error !== e.decode_error) begin
					$error("decode_error expected %0d actual %0d", e.decode_error,
						out_if.decode_error);
					failed = 1'b1;
				end
				if (out_if.total_length !== e.total_length) begin
					$error("total_length expected %0d actual %0d", e.total_length,
						out_if.total_length);
					failed = 1'b1;
				end
			end
			sink_wait = no_idle ? 0 : $urandom_range(0, 3);
		end else if (sink_wait > 0) begin
			sink_wait--;
		end
		out_if.ready <= arst_n && (sink_wait == 0);
	end

	// Sends one compressed byte. Valid stays high on return so that a
	// back-to-back transaction never lowers and raises it in the same step.
	task automatic send_byte(logic [7:0] b, logic last);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_if.valid <= 1'b1;
		in_if.in_byte <= b;
		in_if.in_last <= last;
		do @(posedge clk); while (!in_if.ready);
		decode_byte(b, last);
	endtask

	// Waits for every expected transaction plus a margin, so the block is idle.
	task automatic wait_idle();
		in_if.valid <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(logic [31:0] value);
		cfg_if.valid <= 1'b1;
		cfg_if.data <= value;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		capacity = value;
	endtask

	// Literals at both byte extremes, an overlapping copy and the longest
	// extended copy, which crosses many eight-byte output transactions.
	task automatic test_basic_tokens();
		write_capacity(CAP_MAX);
		send_byte(8'h03, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'haa, 1'b0);
		send_byte(8'h20, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'he0, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'h03, 1'b1);
		wait_idle();
	endtask

	// Each error path: capacity overflow on a literal and on a copy, a
	// reference before the start of the stream, and streams cut mid-token.
	task automatic test_error_cases();
		write_capacity(32'd0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h7e, 1'b1);
		wait_idle();
		write_capacity(32'd2);
		send_byte(8'h00, 1'b0);
		send_byte(8'h11, 1'b0);
		send_byte(8'h20, 1'b0);
		send_byte(8'h00, 1'b1);
		wait_idle();
		write_capacity(CAP_MAX);
		send_byte(8'h3f, 1'b0);
		send_byte(8'hff, 1'b1);
		send_byte(8'h02, 1'b0);
		send_byte(8'h01, 1'b1);
		send_byte(8'hff, 1'b1);
		send_byte(8'h1f, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h42, 1'b0);
		send_byte(8'h40, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h33, 1'b1);
		wait_idle();
	endtask

	// Random streams: mostly well-formed token sequences with random content,
	// some noise bytes and some bad references, under changing capacities.
	task automatic test_random_streams();
		logic [7:0] stream_q [$];
		int sent;
		int gen_cnt;
		int tokens;
		int len;
		int back_dist;
		int streams;
		sent = 0;
		streams = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 5))
				0: write_capacity($urandom_range(0, 40));
				1: write_capacity($urandom);
				default: write_capacity(CAP_MAX);
			endcase
			no_idle = (streams % 5 == 2);
			stream_q.delete();
			gen_cnt = 0;
			tokens = $urandom_range(1, 7);
			repeat (tokens) begin
				if ($urandom_range(0, 9) == 0) begin
					stream_q.push_back(8'($urandom));
				end else if (gen_cnt == 0 || $urandom_range(0, 1) == 0) begin
					len = ($urandom_range(0, 7) == 0) ? 32 : $urandom_range(1, 8);
					stream_q.push_back(8'(len - 1));
					repeat (len) stream_q.push_back(8'($urandom));
					gen_cnt += len;
				end else begin
					len = $urandom_range(1, 7);
					if ($urandom_range(0, 9) == 0)
						back_dist = gen_cnt + 1;
					else
						back_dist = $urandom_range(1, (gen_cnt > WINDOW) ? WINDOW : gen_cnt);
					stream_q.push_back({len[2:0], 5'((back_dist - 1) >> 8)});
					if (len == 7) begin
						stream_q.push_back(8'(($urandom_range(0, 3) == 0) ? $urandom
							: $urandom_range(0, 12)));
						len = 7 + stream_q[stream_q.size() - 1];
					end
					stream_q.push_back(8'(back_dist - 1));
					gen_cnt += len + 2;
				end
			end
			foreach (stream_q[i]) begin
				// Once, hold the input back until the output has fully caught up.
				if (streams == 3 && i == stream_q.size() / 2 && pending_beats.size() != 0) begin
					in_if.valid <= 1'b0;
					while (pending_beats.size() != 0) @(posedge clk);
				end
				send_byte(stream_q[i], i == stream_q.size() - 1);
			end
			sent += stream_q.size();
			streams++;
			wait_idle();
		end
		no_idle = 1'b0;
	endtask

	initial begin
		cycles = 0;
		failed = 1'b0;
		no_idle = 1'b0;
		sink_wait = 0;
		pmode = MODE_CTRL;
		lit_left = '0;
		copy_len = '0;
		dist_hi = '0;
		out_cnt = '0;
		err_sticky = 1'b0;
		capacity = '0;
		arst_n = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.data = '0;
		in_if.valid = 1'b0;
		in_if.in_byte = '0;
		in_if.in_last = 1'b0;
		out_if.ready = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_tokens();
		test_error_cases();
		test_random_streams();
		if (!failed) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
